@@ rtl/coc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the chord order counter.
// No dependencies; every other file imports this package.
package coc_pkg;

    // Default vector width and the fixed width of the payload fields
    localparam int CocWidth  = 16;
    localparam int CocFieldW = 16;

    // Step order held in the mode register
    typedef enum logic {
        MODE_BINARY = 1'b0,
        MODE_CHORD  = 1'b1
    } t_order_mode;

endpackage

@@ rtl/coc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the chord order counter.
// Depends on coc_pkg for the payload field width.
interface coc_in_if
    import coc_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic                 load;
    logic [CocFieldW-1:0] load_value;

    modport source (output valid, load, load_value, input ready);
    modport sink   (input valid, load, load_value, output ready);
endinterface

interface coc_out_if
    import coc_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [CocFieldW-1:0] count_value;
    logic [CocFieldW-1:0] gray_value;
    logic                 wrapped;

    modport source (output valid, count_value, gray_value, wrapped, input ready);
    modport sink   (input valid, count_value, gray_value, wrapped, output ready);
endinterface

@@ rtl/chord_order_counter.sv @@
`timescale 1ns / 1ps
// Chord order counter: input register, next-value step, result register.
// Depends on coc_pkg, coc_in_if/coc_out_if and coc_step.
//
// Usage:
//   i_in carries one beat per item: load = 1 replaces the vector with
//   load_value (masked to WIDTH bits), load = 0 advances it one step.
//   o_out returns one beat per item: the new vector (low 16 bits), its
//   Gray code and a wrapped flag, set when a step went from all ones to 0.
//   i_cfg_we / i_cfg_wdata write the order mode (0 = binary increment,
//   1 = chord order); write it only while no beat is in flight.
// Path: a beat accepted into the input register moves to the result register, which drives o_out.
// Throughput: one beat per cycle while the result register is empty or o_out.ready is high;
//   the vector register and its step logic form one loop, so back-to-back beats see each other's result.
// Reset (i_rst_n low at a clock edge): vector cleared to zero, mode set to
//   chord order, both pipeline registers emptied.
// Stall: while o_out.ready is low and a result waits, the input register
//   fills once more and then i_in.ready drops until the result is taken.
module chord_order_counter
    import coc_pkg::*;
#(
    parameter int WIDTH = CocWidth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    coc_in_if.sink        i_in,
    coc_out_if.source     o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);

    localparam int ExtW = WIDTH + CocFieldW;

    // Input register
    logic                 r_in_valid;
    logic                 r_load;
    logic [CocFieldW-1:0] r_load_value;

    // Counter state and mode
    logic [WIDTH-1:0]     r_vec;
    t_order_mode          r_mode;

    // Result register
    logic                 r_out_valid;
    logic [CocFieldW-1:0] r_out_count;
    logic [CocFieldW-1:0] r_out_gray;
    logic                 r_out_wrap;

    logic                 w_advance;
    logic [WIDTH-1:0]     w_step;
    logic                 w_step_wrap;
    logic [ExtW-1:0]      w_load_ext;
    logic [WIDTH-1:0]     n_vec;
    logic                 n_wrap;
    logic [WIDTH-1:0]     w_gray;
    logic [ExtW-1:0]      w_count_ext;
    logic [ExtW-1:0]      w_gray_ext;
    logic [ExtW-1:0]      w_cur_ext;

    // Pipeline moves when the result register is empty or being drained
    assign w_advance  = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || w_advance;

    coc_step #(
        .WIDTH (WIDTH)
    ) u_step (
        .i_vec  (r_vec),
        .i_mode (r_mode),
        .o_next (w_step),
        .o_wrap (w_step_wrap)
    );

    // Load or step, then fit to the 16-bit result fields
    assign w_load_ext  = {{WIDTH{1'b0}}, r_load_value};
    assign n_vec       = r_load ? w_load_ext[WIDTH-1:0] : w_step;
    assign n_wrap      = !r_load && w_step_wrap;
    assign w_gray      = n_vec ^ (n_vec >> 1);
    assign w_count_ext = {{CocFieldW{1'b0}}, n_vec};
    assign w_gray_ext  = {{CocFieldW{1'b0}}, w_gray};
    assign w_cur_ext   = {{CocFieldW{1'b0}}, r_vec};

    // Capture input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_load       <= i_in.load;
            r_load_value <= i_in.load_value;
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CHORD;
        end else if (i_cfg_we) begin
            r_mode <= t_order_mode'(i_cfg_wdata);
        end
    end

    // Update the vector and hold the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_vec <= n_vec;
            end
        end
        if (w_advance && r_in_valid) begin
            r_out_count <= w_count_ext[CocFieldW-1:0];
            r_out_gray  <= w_gray_ext[CocFieldW-1:0];
            r_out_wrap  <= n_wrap;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.count_value = r_out_count;
    assign o_out.gray_value  = r_out_gray;
    assign o_out.wrapped     = r_out_wrap;

`ifndef SYNTHESIS
    // A wrapped beat always carries zero
    a_wrap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.wrapped |-> o_out.count_value == '0)
        else $error("wrapped result with nonzero count");

    // The waiting result matches the live vector
    a_out_tracks_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.count_value == w_cur_ext[CocFieldW-1:0])
        else $error("result beat out of step with vector");

    // A load beat lands in the vector unchanged
    a_load_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_advance && r_load |=> r_vec == $past(w_load_ext[WIDTH-1:0]))
        else $error("load value lost");

    // An empty result register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

@@ rtl/coc_step.sv @@
`timescale 1ns / 1ps
// Next-value logic of the counter: chord order or binary increment.
// Depends on coc_pkg for the order mode type.
module coc_step
    import coc_pkg::*;
#(
    parameter int WIDTH = CocWidth
) (
    input  logic [WIDTH-1:0] i_vec,
    input  t_order_mode      i_mode,
    output logic [WIDTH-1:0] o_next,
    output logic             o_wrap
);

    localparam int IW = $clog2(WIDTH);

    logic [WIDTH-1:0] w_lowest;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   w_flip;
    logic [IW-1:0]    w_lsb;
    logic [IW:0]      w_pack_sh;
    logic [WIDTH:0]   w_packed;
    logic [WIDTH:0]   w_refill;
    logic             w_all_ones;
    logic             w_zero;
    logic [WIDTH-1:0] w_chord;

    // Isolate the lowest set bit and ripple it through the lowest run of ones
    assign w_lowest   = i_vec & (~i_vec + WIDTH'(1));
    assign w_sum      = {1'b0, i_vec} + {1'b0, w_lowest};
    assign w_flip     = {1'b0, i_vec} ^ w_sum;
    assign w_all_ones = &i_vec;
    assign w_zero     = (i_vec == '0);

    // Position of the lowest set bit
    always_comb begin
        w_lsb = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                w_lsb = IW'(i);
            end
        end
    end

    // Run of ones minus the moved bit, packed down to bit 0
    assign w_pack_sh = {1'b0, w_lsb} + (IW + 1)'(2);
    assign w_packed  = w_flip >> w_pack_sh;
    // Run reached the top: refill with one more set bit from bit 0
    assign w_refill  = w_flip >> w_lsb;

    always_comb begin
        priority if (w_all_ones) begin
            w_chord = '0;
        end else if (w_zero) begin
            w_chord = WIDTH'(1);
        end else if (w_sum[WIDTH]) begin
            w_chord = w_refill[WIDTH-1:0];
        end else begin
            w_chord = w_sum[WIDTH-1:0] | w_packed[WIDTH-1:0];
        end
    end

    // Select the order; both wrap from all ones to zero
    always_comb begin
        o_wrap = w_all_ones;
        unique case (i_mode)
            MODE_CHORD:  o_next = w_chord;
            MODE_BINARY: o_next = i_vec + WIDTH'(1);
            default:     o_next = i_vec + WIDTH'(1);
        endcase
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chord_order_counter: bursty load/step beats in both
// step orders, a predictor of the vector and a field-by-field result check.
// Depends on coc_pkg, coc_in_if/coc_out_if and the chord_order_counter RTL.
module tb_top;
    import coc_pkg::*;

    localparam int VecW       = CocWidth;
    localparam int IdleLimit  = 2000;
    localparam int HoldCycles = 200;
    localparam int PhaseItems = 170;
    localparam int FloodItems = 60;

    typedef struct packed {
        logic [CocFieldW-1:0] count_value;
        logic [CocFieldW-1:0] gray_value;
        logic                 wrapped;
    } t_count_result;

    typedef enum int {
        RX_OPEN,
        RX_BUSY,
        RX_EVERY3,
        RX_SPARSE
    } t_rx_pattern;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    coc_in_if  in_bus ();
    coc_out_if out_bus ();

    // Predicted vector, mode copy and pending results
    logic [VecW-1:0] vec_model  = '0;
    t_order_mode     mode_model = MODE_CHORD;
    t_count_result   result_q[$];

    int   err_cnt     = 0;
    int   idle_cycles = 0;
    int   hold_req    = 0;
    int   burst_left  = 0;
    logic gaps_off    = 1'b0;

    always #1 clk = ~clk;

    chord_order_counter #(
        .WIDTH(VecW)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // Mask of the n lowest bits
    function automatic logic [VecW-1:0] low_ones(input int n);
        logic [VecW-1:0] m;
        m = '0;
        for (int i = 0; i < VecW; i++) begin
            if (i < n) m[i] = 1'b1;
        end
        return m;
    endfunction

    function automatic int ones_count(input logic [VecW-1:0] v);
        int c;
        c = 0;
        for (int i = 0; i < VecW; i++) begin
            if (v[i]) c++;
        end
        return c;
    endfunction

    // Next value with the same number of set bits, else one more set bit, or zero after all ones
    function automatic logic [VecW-1:0] chord_step(input logic [VecW-1:0] v,
                                                   output logic wrap);
        int              pos;
        int              below;
        int              k;
        logic [VecW-1:0] nxt;
        pos  = VecW;
        wrap = 1'b0;
        for (int i = 0; i < VecW - 1; i++) begin
            if (pos == VecW && v[i] && !v[i+1]) pos = i;
        end
        if (pos < VecW - 1) begin
            below     = ones_count(v & low_ones(pos));
            nxt       = v & ~low_ones(pos + 1);
            nxt[pos+1] = 1'b1;
            nxt       = nxt | low_ones(below);
        end else begin
            k = ones_count(v) + 1;
            if (k > VecW) begin
                wrap = 1'b1;
                nxt  = '0;
            end else begin
                nxt = low_ones(k);
            end
        end
        return nxt;
    endfunction

    // Apply one beat to the predicted vector and form its result
    function automatic t_count_result predict_beat(input logic ld,
                                                   input logic [CocFieldW-1:0] val);
        t_count_result r;
        logic          wrap;
        wrap = 1'b0;
        if (ld) begin
            vec_model = val[VecW-1:0];
        end else if (mode_model == MODE_CHORD) begin
            vec_model = chord_step(vec_model, wrap);
        end else begin
            wrap      = &vec_model;
            vec_model = vec_model + 1'b1;
        end
        r.count_value = vec_model[CocFieldW-1:0];
        r.gray_value  = vec_model ^ (vec_model >> 1);
        r.wrapped     = wrap;
        return r;
    endfunction

    // Load values biased toward dense, single-bit and all-ones patterns
    function automatic logic [CocFieldW-1:0] pick_load_value();
        logic [CocFieldW-1:0] v;
        v = CocFieldW'($urandom);
        case ($urandom_range(0, 4))
            0: v = '1;
            1: begin
                v = '1;
                v[$urandom_range(0, CocFieldW - 1)] = 1'b0;
            end
            2: begin
                v = '0;
                v[$urandom_range(0, CocFieldW - 1)] = 1'b1;
            end
            3: v = v | (v << 1) | 16'hF000;
            default: ;
        endcase
        return v;
    endfunction

    // Check each output beat against the oldest prediction, then record input beats
    always @(posedge clk) begin : chk
        t_count_result want;
        if (rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected beat count_value %h gray_value %h wrapped %b",
                             $time, out_bus.count_value, out_bus.gray_value,
                             out_bus.wrapped);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    if (out_bus.count_value !== want.count_value) begin
                        $display("%0t: count_value expected %h got %h",
                                 $time, want.count_value, out_bus.count_value);
                        err_cnt++;
                    end
                    if (out_bus.gray_value !== want.gray_value) begin
                        $display("%0t: gray_value expected %h got %h",
                                 $time, want.gray_value, out_bus.gray_value);
                        err_cnt++;
                    end
                    if (out_bus.wrapped !== want.wrapped) begin
                        $display("%0t: wrapped expected %b got %b",
                                 $time, want.wrapped, out_bus.wrapped);
                        err_cnt++;
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                result_q.push_back(predict_beat(in_bus.load, in_bus.load_value));
            end
        end
    end

    // End the run after too many cycles without a beat on either side
    always @(posedge clk) begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drive output ready: randomly chosen stall patterns plus the long hold on request
    initial begin : rx_stall
        int          hold_cnt;
        int          hold_seen;
        int          phase;
        t_rx_pattern pat;
        logic        rdy;
        hold_cnt      = 0;
        hold_seen     = 0;
        phase         = 0;
        pat           = RX_OPEN;
        out_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_cnt  = HoldCycles;
            end
            if (phase == 0) begin
                pat   = t_rx_pattern'($urandom_range(0, 3));
                phase = $urandom_range(20, 100);
            end else begin
                phase--;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else begin
                case (pat)
                    RX_OPEN:   rdy = 1'b1;
                    RX_BUSY:   rdy = ($urandom_range(0, 9) < 7);
                    RX_EVERY3: rdy = (phase % 3 == 0);
                    default:   rdy = ($urandom_range(0, 9) < 3);
                endcase
            end
            out_bus.ready <= rdy;
        end
    end

    // Offer one beat and hold it until accepted; unless gaps are off, insert a gap at the end of a burst
    task automatic send_beat(input logic ld, input logic [CocFieldW-1:0] val);
        in_bus.valid      <= 1'b1;
        in_bus.load       <= ld;
        in_bus.load_value <= val;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        if (!gaps_off) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                in_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 10);
            end
        end
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_mode(input t_order_mode m);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we     <= 1'b0;
        mode_model = m;
    endtask

    // Chord order from reset: zero, all ones, top bit, packing and dense values
    task automatic test_chord_corners();
        send_beat(1'b0, 16'h0000);
        send_beat(1'b0, 16'hFFFF);
        send_beat(1'b1, 16'hFFFF);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'h8000);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'h00F0);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'h7FFF);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'hFFFE);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'h5555);
    endtask

    // Binary order: wrap from all ones, step from zero, carry chains
    task automatic test_binary_corners();
        write_mode(MODE_BINARY);
        send_beat(1'b1, 16'hFFFF);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b0, 16'hFFFF);
        send_beat(1'b1, 16'h7FFF);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'hAAAA);
        send_beat(1'b0, 16'h0000);
    endtask

    // Mostly steps with occasional biased loads
    task automatic test_random_phase(input t_order_mode m, input int n_items);
        write_mode(m);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_beat(1'b1, pick_load_value());
            end else begin
                send_beat(1'b0, CocFieldW'($urandom));
            end
        end
    endtask

    // Hold the receiver off while beats keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req <= hold_req + 1;
        gaps_off = 1'b1;
        for (int i = 0; i < FloodItems; i++) begin
            send_beat(i == 0, (i == 0) ? 16'h0FFF : CocFieldW'($urandom));
        end
        gaps_off = 1'b0;
    endtask

    initial begin
        in_bus.valid      = 1'b0;
        in_bus.load       = 1'b0;
        in_bus.load_value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_chord_corners();
        test_binary_corners();
        test_random_phase(MODE_CHORD, PhaseItems);
        test_random_phase(MODE_BINARY, PhaseItems);
        test_random_phase(MODE_CHORD, PhaseItems);
        test_backpressure();
        test_random_phase(MODE_BINARY, PhaseItems);
        test_random_phase(MODE_CHORD, PhaseItems);

        wait_drained();
        repeat (4) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ chord_order_counter.f @@
rtl/coc_pkg.sv
rtl/coc_if.sv
rtl/coc_step.sv
rtl/chord_order_counter.sv
dv/tb_top.sv
